// ===== hdl/bounded_deque_indexed_macros.svh =====
// Assertion helpers shared by the deque modules.
`ifndef BOUNDED_DEQUE_INDEXED_MACROS_SVH
`define BOUNDED_DEQUE_INDEXED_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BDI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold in the cycle after a trigger.
`define BDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdi_pkg.sv =====
package bdi_pkg;

  localparam int CAPACITY    = 256;
  localparam int ENTRY_WIDTH = 32;

  localparam int ACT_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int STS_W  = 2;
  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_HEAD  = 3'd0,
    ACT_INS_TAIL  = 3'd1,
    ACT_REM_HEAD  = 3'd2,
    ACT_REM_TAIL  = 3'd3,
    ACT_READ_HEAD = 3'd4,
    ACT_READ_TAIL = 3'd5,
    ACT_READ_IDX  = 3'd6
  } action_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } bdi_cmd_t;

  typedef struct packed {
    logic out_free;
  } bdi_sts_t;

endpackage

// ===== hdl/bounded_deque_indexed.sv =====
// Bounded double-ended queue with indexed reads.
// Input channel (in_valid_i/in_ready_o) carries one item: an action code,
// an entry to insert and a logical position from the head. Actions insert
// or remove at either end, read either end, or read by position.
// Output channel (out_valid_o/out_ready_i) returns one result per item:
// the entry read (zero unless read_valid_o), the count after the action
// and a status code (ok, full insert ignored, empty, position out of range).
// Entries sit in a single-port ring buffer addressed by a start pointer and
// a count, so each insert or read is one store access.
// A new item is not accepted until the previous one is through; each item
// passes three steps: capture, store access (the
// registered read of the single memory port), output load.
// The input reopens as soon as the result is loaded, while that result may
// still wait in the output register; if the receiver stalls, the next item
// waits in its load step until the output register is taken.
// Reset empties the queue (start and count to zero) and clears the output
// valid; store contents are not cleared and are only read where written.
module bounded_deque_indexed (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bdi_pkg::ACT_W-1:0]   action_i,
  input  logic [bdi_pkg::DATA_W-1:0]  entry_data_i,
  input  logic [bdi_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bdi_pkg::DATA_W-1:0]  read_data_o,
  output logic                        read_valid_o,
  output logic [bdi_pkg::CNT_W-1:0]   entry_count_o,
  output logic [bdi_pkg::STS_W-1:0]   status_o
);
  import bdi_pkg::*;

  bdi_cmd_t cmd;
  bdi_sts_t sts;

  // sequencer: idle -> exec -> load
  bdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // ring buffer, pointers and output register
  bdi_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .entry_data_i  (entry_data_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .read_valid_o  (read_valid_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule

// ===== hdl/bdi_ctrl.sv =====
`include "bounded_deque_indexed_macros.svh"

module bdi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdi_pkg::bdi_sts_t sts_i,
  output bdi_pkg::bdi_cmd_t cmd_o
);
  import bdi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        // hold the read word until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `BDI_ASSERT_NEXT(a_capture_exec, cmd_o.capture, state_q == ST_EXEC, "capture must go to exec")
  `BDI_ASSERT_NEXT(a_load_idle, cmd_o.load, in_ready_o, "load must reopen input")

endmodule

// ===== hdl/bdi_datapath.sv =====
`include "bounded_deque_indexed_macros.svh"

module bdi_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bdi_pkg::bdi_cmd_t           cmd_i,
  output bdi_pkg::bdi_sts_t           sts_o,
  input  logic [bdi_pkg::ACT_W-1:0]   action_i,
  input  logic [bdi_pkg::DATA_W-1:0]  entry_data_i,
  input  logic [bdi_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bdi_pkg::DATA_W-1:0]  read_data_o,
  output logic                        read_valid_o,
  output logic [bdi_pkg::CNT_W-1:0]   entry_count_o,
  output logic [bdi_pkg::STS_W-1:0]   status_o
);
  import bdi_pkg::*;

  // latched item
  logic [ACT_W-1:0]  act_q;
  logic [DATA_W-1:0] data_q;
  logic [POS_W-1:0]  pos_q;

  // deque state
  logic [PTR_W-1:0] start_q, start_d;
  logic [CNT_W-1:0] count_q, count_d;

  // exec results
  status_e sts_q, sts_d;
  logic    rv_q, rv_d;

  // entry store
  logic [ENTRY_WIDTH-1:0] mem_q [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rd_q;
  logic                   we, re;
  logic [PTR_W-1:0]       addr, off;

  // output register
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_data_q;
  logic                out_rv_q;
  logic [CNT_W-1:0]    out_cnt_q;
  status_e             out_sts_q;

  logic             full, empty;
  logic [PTR_W-1:0] start_dec, start_inc, slot;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count_m1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      data_q <= entry_data_i;
      pos_q  <= position_i;
    end
  end

  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - 1'b1;
  assign start_dec = (start_q == '0) ? PTR_W'(CAPACITY - 1) : start_q - 1'b1;
  assign start_inc = (start_q == PTR_W'(CAPACITY - 1)) ? '0 : start_q + 1'b1;

  // ring slot of a logical offset: one compare and subtract
  assign sum  = {1'b0, start_q} + {1'b0, off};
  assign slot = (sum >= SUM_W'(CAPACITY)) ? PTR_W'(sum - SUM_W'(CAPACITY)) : sum[PTR_W-1:0];

  always_comb begin
    start_d = start_q;
    count_d = count_q;
    sts_d   = STS_OK;
    rv_d    = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    off     = '0;
    addr    = slot;
    case (action_e'(act_q))
      ACT_INS_HEAD: begin
        if (full) begin
          sts_d = STS_FULL;
        end else begin
          start_d = start_dec;
          addr    = start_dec;
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_INS_TAIL: begin
        if (full) begin
          sts_d = STS_FULL;
        end else begin
          off     = count_q[PTR_W-1:0];
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_REM_HEAD: begin
        if (empty) begin
          sts_d = STS_EMPTY;
        end else begin
          start_d = start_inc;
          count_d = count_m1;
        end
      end
      ACT_REM_TAIL: begin
        if (empty) begin
          sts_d = STS_EMPTY;
        end else begin
          count_d = count_m1;
        end
      end
      ACT_READ_HEAD: begin
        if (empty) begin
          sts_d = STS_EMPTY;
        end else begin
          re   = 1'b1;
          rv_d = 1'b1;
        end
      end
      ACT_READ_TAIL: begin
        if (empty) begin
          sts_d = STS_EMPTY;
        end else begin
          off  = count_m1[PTR_W-1:0];
          re   = 1'b1;
          rv_d = 1'b1;
        end
      end
      ACT_READ_IDX: begin
        if (CMP_W'(pos_q) >= CMP_W'(count_q)) begin
          sts_d = STS_RANGE;
        end else begin
          off  = PTR_W'(pos_q);
          re   = 1'b1;
          rv_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem_q[addr] <= ENTRY_WIDTH'(data_q);
    end
    if (cmd_i.exec && re) begin
      rd_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      start_q <= start_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      sts_q <= sts_d;
      rv_q  <= rv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= rv_q ? DATA_W'(rd_q) : '0;
      out_rv_q   <= rv_q;
      out_cnt_q  <= count_q;
      out_sts_q  <= sts_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_data_q;
  assign read_valid_o  = out_rv_q;
  assign entry_count_o = out_cnt_q;
  assign status_o      = out_sts_q;

  `BDI_ASSERT(a_count_max, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `BDI_ASSERT_NEXT(a_empty_hold, cmd_i.exec && empty && rv_d, 1'b0, "read on empty list")
  `BDI_ASSERT_NEXT(a_full_hold, cmd_i.exec && sts_d == STS_FULL,
                   $stable(count_q) && $stable(start_q), "full insert changed state")

endmodule

// ===== sim/bounded_deque_indexed_checker.sv =====
module bounded_deque_indexed_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [bdi_pkg::ACT_W-1:0]  action_i,
  input  logic [bdi_pkg::DATA_W-1:0] entry_data_i,
  input  logic [bdi_pkg::POS_W-1:0]  position_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [bdi_pkg::DATA_W-1:0] read_data_i,
  input  logic                       read_valid_i,
  input  logic [bdi_pkg::CNT_W-1:0]  entry_count_i,
  input  logic [bdi_pkg::STS_W-1:0]  status_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import bdi_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic [CNT_W-1:0]  entry_count;
    status_e           status;
  } deque_result_t;

  // shadow deque: ring of entries, head slot and fill level
  logic [ENTRY_WIDTH-1:0] shadow_store [CAPACITY];
  int unsigned            shadow_head;
  int unsigned            shadow_fill;
  deque_result_t          expected_q [$];
  int                     result_index;

  function automatic deque_result_t apply_action(logic [ACT_W-1:0] act,
                                                 logic [DATA_W-1:0] data,
                                                 logic [POS_W-1:0] pos);
    deque_result_t res;
    int unsigned   offset;
    res        = '0;
    res.status = STS_OK;
    case (act)
      ACT_INS_HEAD: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = STS_FULL;
        end else begin
          shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
          shadow_store[PTR_W'(shadow_head)] = data[ENTRY_WIDTH-1:0];
          shadow_fill++;
        end
      end
      ACT_INS_TAIL: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = STS_FULL;
        end else begin
          shadow_store[PTR_W'((shadow_head + shadow_fill) % CAPACITY)] = data[ENTRY_WIDTH-1:0];
          shadow_fill++;
        end
      end
      ACT_REM_HEAD: begin
        if (shadow_fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % CAPACITY;
          shadow_fill--;
        end
      end
      ACT_REM_TAIL: begin
        if (shadow_fill == 0) res.status = STS_EMPTY;
        else shadow_fill--;
      end
      ACT_READ_HEAD, ACT_READ_TAIL: begin
        if (shadow_fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          offset = (act == ACT_READ_HEAD) ? 0 : shadow_fill - 1;
          res.read_data  =
            DATA_W'(shadow_store[PTR_W'((shadow_head + offset) % CAPACITY)]);
          res.read_valid = 1'b1;
        end
      end
      ACT_READ_IDX: begin
        if (pos >= shadow_fill) begin
          res.status = STS_RANGE;
        end else begin
          res.read_data  = DATA_W'(shadow_store[PTR_W'((shadow_head + pos) % CAPACITY)]);
          res.read_valid = 1'b1;
        end
      end
      default: ;  // unused action code: no effect
    endcase
    res.entry_count = CNT_W'(shadow_fill);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
             $time, result_index, field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      shadow_head = 0;
      shadow_fill = 0;
      expected_q.delete();
      pending_o = 0;
      fail_count_o = 0;
      result_index = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item pending", read_data_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (read_data_i !== want.read_data)
            report_mismatch("read_data", read_data_i, want.read_data);
          if (read_valid_i !== want.read_valid)
            report_mismatch("read_valid", DATA_W'(read_valid_i), DATA_W'(want.read_valid));
          if (entry_count_i !== want.entry_count)
            report_mismatch("entry_count", DATA_W'(entry_count_i), DATA_W'(want.entry_count));
          if (status_i !== want.status)
            report_mismatch("status", DATA_W'(status_i), DATA_W'(want.status));
        end
        result_index++;
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(apply_action(action_i, entry_data_i, position_i));
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/bounded_deque_indexed_tb.sv =====
module bounded_deque_indexed_tb;
  import bdi_pkg::*;

  // action code 7 is outside the enum; the block must treat it as a no-op
  localparam logic [ACT_W-1:0] ACT_NOP = 3'd7;

  // watchdog limit, with a wide margin over the slowest run
  localparam int CYCLE_LIMIT  = 200000;
  // allow some slack at the end, after the last result is taken
  localparam int DRAIN_CYCLES = 16;
  // a phase ends after the segment that crosses this count; a full fill
  // or drain segment alone runs about 370 items
  localparam int PHASE_ITEMS  = 200;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } stim_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ACT_W-1:0]  action_i;
  logic [DATA_W-1:0] entry_data_i;
  logic [POS_W-1:0]  position_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DATA_W-1:0] read_data_o;
  logic              read_valid_o;
  logic [CNT_W-1:0]  entry_count_o;
  logic [STS_W-1:0]  status_o;

  int fail_count;
  int pending;
  int cycle_count;

  // percentages of idle cycles on each side, set per phase
  int idle_pct;
  int stall_pct;

  // entries the deque holds once every item sent so far is applied;
  // used only to steer stimulus toward full and empty
  int level;
  int items_sent;

  bounded_deque_indexed dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .entry_data_i  (entry_data_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .read_valid_o  (read_valid_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

  bounded_deque_indexed_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .entry_data_i  (entry_data_i),
    .position_i    (position_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_i   (read_data_o),
    .read_valid_i  (read_valid_o),
    .entry_count_i (entry_count_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: ends a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bounded_deque_indexed: mismatch");
    $finish;
  end

  // Sender: optional idle cycles, then hold the item until accepted.
  // Ready is sampled at the falling edge, so the accept decision never
  // races the block's own update at the rising edge.
  task automatic send_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] data,
                           logic [POS_W-1:0] pos);
    logic ready_seen;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    entry_data_i <= data;
    position_i   <= pos;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    items_sent++;
    case (act)
      ACT_INS_HEAD, ACT_INS_TAIL: if (level < CAPACITY) level++;
      ACT_REM_HEAD, ACT_REM_TAIL: if (level > 0) level--;
      default: ;
    endcase
  endtask

  function automatic logic [ACT_W-1:0] pick_insert();
    return $urandom_range(1) ? ACT_INS_TAIL : ACT_INS_HEAD;
  endfunction

  function automatic logic [ACT_W-1:0] pick_remove();
    return $urandom_range(1) ? ACT_REM_TAIL : ACT_REM_HEAD;
  endfunction

  // reads lean toward read-by-index, the most varied of the three
  function automatic logic [ACT_W-1:0] pick_read();
    int r;
    r = $urandom_range(3);
    if (r == 0) return ACT_READ_HEAD;
    if (r == 1) return ACT_READ_TAIL;
    return ACT_READ_IDX;
  endfunction

  task automatic random_item(stim_mode_e mode);
    int               roll;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL:  act = (roll < 75) ? pick_insert() : (roll < 80) ? pick_remove() : pick_read();
      MODE_DRAIN: act = (roll < 75) ? pick_remove() : (roll < 80) ? pick_insert() : pick_read();
      default:    act = ACT_W'($urandom_range(7));
    endcase
    // positions mostly inside or just past the fill, sometimes anywhere
    if ($urandom_range(3) == 0 || level == 0 || level >= CAPACITY) pos = POS_W'($urandom);
    else pos = POS_W'($urandom_range(level));
    send_item(act, $urandom, pos);
  endtask

  // run toward full or empty, then keep pushing at the limit for a while; mixed mode sends a random run
  task automatic run_segment(stim_mode_e mode);
    int extra;
    extra = $urandom_range(2, 8);
    case (mode)
      MODE_FILL: begin
        while (level < CAPACITY) random_item(mode);
        repeat (extra) random_item(mode);
      end
      MODE_DRAIN: begin
        while (level > 0) random_item(mode);
        repeat (extra) random_item(mode);
      end
      default: repeat ($urandom_range(20, 60)) random_item(MODE_MIXED);
    endcase
  endtask

  initial begin
    int phase_end;
    int roll;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_NOP;
    entry_data_i = '0;
    position_i   = '0;
    out_ready_i  = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    level        = 0;
    items_sent   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every remove and read action, and the unused code, on an empty list first
    send_item(ACT_REM_HEAD,  '0, '0);
    send_item(ACT_REM_TAIL,  '0, '0);
    send_item(ACT_READ_HEAD, '0, '0);
    send_item(ACT_READ_TAIL, '0, '0);
    send_item(ACT_READ_IDX,  '0, '0);
    send_item(ACT_NOP,       '0, '0);
    // extreme payloads at both ends
    send_item(ACT_INS_TAIL, 32'hFFFF_FFFF, '0);
    send_item(ACT_INS_HEAD, 32'h0000_0000, '1);
    send_item(ACT_INS_TAIL, 32'hA5A5_A5A5, '0);
    send_item(ACT_INS_HEAD, 32'h5A5A_5A5A, '0);
    send_item(ACT_READ_HEAD, '0, '0);
    send_item(ACT_READ_TAIL, '0, '0);
    send_item(ACT_READ_IDX,  '0, 8'd0);
    send_item(ACT_READ_IDX,  '0, 8'd3);
    // index at the count, and the largest index
    send_item(ACT_READ_IDX,  '0, 8'd4);
    send_item(ACT_READ_IDX,  '0, 8'd255);
    send_item(ACT_NOP,       32'hFFFF_FFFF, 8'd255);
    send_item(ACT_REM_HEAD,  '0, '0);
    send_item(ACT_REM_TAIL,  '0, '0);
    send_item(ACT_READ_IDX,  '0, 8'd1);
    send_item(ACT_REM_HEAD,  '0, '0);
    send_item(ACT_REM_TAIL,  '0, '0);
    send_item(ACT_REM_HEAD,  '0, '0);

    // random: four backpressure phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 50; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 70) run_segment((level < CAPACITY / 2) ? MODE_FILL : MODE_DRAIN);
        else run_segment(MODE_MIXED);
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("bounded_deque_indexed: match");
    end else begin
      $display("bounded_deque_indexed: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bdi_pkg.sv
hdl/bdi_ctrl.sv
hdl/bdi_datapath.sv
hdl/bounded_deque_indexed.sv
sim/bounded_deque_indexed_checker.sv
sim/bounded_deque_indexed_tb.sv
